FILE: rtl/sba_pkg.sv
// Shared types, constants and block-class tables of the segregated block allocator.
package sba_pkg;

  localparam int unsigned POOL_BYTES        = 1048576;
  localparam int unsigned POOL_WORDS        = POOL_BYTES / 4;
  localparam int unsigned MAX_REQUEST_BYTES = 2076;

  localparam int ADDR_W = 20;
  localparam int LINK_W = 21;
  localparam int WORD_W = 18;
  localparam int CLS_W  = 5;
  localparam int LEFT_W = 11;
  localparam int BYTES_W = 12;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(1) << ADDR_W;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_EXT  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic cap;
    logic dec;
    logic fin;
  } sba_cmd_t;

  typedef struct packed {
    logic need_rd;
  } sba_sts_t;

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] idx);
    logic [BYTES_W-1:0] b;
    case (idx)
      5'd0:    b = 12'd12;
      5'd1:    b = 12'd16;
      5'd2:    b = 12'd28;
      5'd3:    b = 12'd36;
      5'd4:    b = 12'd60;
      5'd5:    b = 12'd76;
      5'd6:    b = 12'd88;
      5'd7:    b = 12'd116;
      5'd8:    b = 12'd148;
      5'd9:    b = 12'd196;
      5'd10:   b = 12'd260;
      5'd11:   b = 12'd292;
      5'd12:   b = 12'd436;
      5'd13:   b = 12'd676;
      5'd14:   b = 12'd868;
      5'd15:   b = 12'd1068;
      5'd16:   b = 12'd2076;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [LEFT_W-1:0] class_blocks(input logic [CLS_W-1:0] idx);
    logic [LEFT_W-1:0] n;
    case (idx)
      5'd0:    n = 11'd1024;
      5'd1:    n = 11'd1024;
      5'd2:    n = 11'd585;
      5'd3:    n = 11'd455;
      5'd4:    n = 11'd273;
      5'd5:    n = 11'd215;
      5'd6:    n = 11'd186;
      5'd7:    n = 11'd141;
      5'd8:    n = 11'd110;
      5'd9:    n = 11'd83;
      5'd10:   n = 11'd63;
      5'd11:   n = 11'd56;
      5'd12:   n = 11'd37;
      5'd13:   n = 11'd24;
      5'd14:   n = 11'd18;
      5'd15:   n = 11'd15;
      5'd16:   n = 11'd7;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [LINK_W-1:0] chunk_bytes(input logic [CLS_W-1:0] idx);
    logic [LINK_W-1:0] c;
    case (idx)
      5'd0:    c = LINK_W'(12 * 1024);
      5'd1:    c = LINK_W'(16 * 1024);
      5'd2:    c = LINK_W'(28 * 585);
      5'd3:    c = LINK_W'(36 * 455);
      5'd4:    c = LINK_W'(60 * 273);
      5'd5:    c = LINK_W'(76 * 215);
      5'd6:    c = LINK_W'(88 * 186);
      5'd7:    c = LINK_W'(116 * 141);
      5'd8:    c = LINK_W'(148 * 110);
      5'd9:    c = LINK_W'(196 * 83);
      5'd10:   c = LINK_W'(260 * 63);
      5'd11:   c = LINK_W'(292 * 56);
      5'd12:   c = LINK_W'(436 * 37);
      5'd13:   c = LINK_W'(676 * 24);
      5'd14:   c = LINK_W'(868 * 18);
      5'd15:   c = LINK_W'(1068 * 15);
      5'd16:   c = LINK_W'(2076 * 7);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/segregated_block_allocator_top.sv
// Top level of the segregated block allocator: controller plus datapath.
//
// A request is taken at a rising edge with start high and busy low. It carries
// in_req_type (allocate, free, clear), in_request_bytes and in_free_address.
// Exactly one result follows for every request: out_strobe is high for one
// cycle with out_status, out_user_address and out_size_class, and the result
// transfer completes at the edge that ends that cycle. There is no way to
// stall results; none is needed because a new request is only taken after
// the previous result has been produced.
// Clear, carve from a chunk, and requests rejected on their fields alone set
// their result in the decode state; a free-list pop and a free need one read
// of the block word memory and set theirs, or a reject on a bad header, in
// the read state. The result is registered onto the outputs. The single
// synchronous read port of the block word memory is what needs that read state.
// Reset (synchronous, rst_n low) empties all free lists, the carving state
// and the pool. The block word memory is not cleared; a free below the pool
// top whose header word was never written reads back whatever it holds.
module segregated_block_allocator_top import sba_pkg::*; #(
  parameter int NUM_CLASSES = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_request_bytes,
  input  logic [31:0]       in_free_address,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_user_address,
  output logic [CLS_W-1:0]  out_size_class
);

  sba_cmd_t cmd;
  sba_sts_t sts;

  sba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  sba_datapath #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_req_type      (in_req_type),
    .in_request_bytes (in_request_bytes),
    .in_free_address  (in_free_address),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_size_class   (out_size_class)
  );

endmodule

FILE: rtl/sba_ctrl.sv
// Sequencing state machine of the segregated block allocator.
module sba_ctrl import sba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sba_sts_t sts_i,
  output sba_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = sts_i.need_rd ? S_RD : S_IDLE;
      end
      S_RD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd_o.cap = start && (state_r == S_IDLE);
  assign cmd_o.dec = (state_r == S_DEC);
  assign cmd_o.fin = (state_r == S_RD);

endmodule

FILE: rtl/sba_datapath.sv
// Class tables, list heads, carving state, block word memory and result register.
module sba_datapath import sba_pkg::*; #(
  parameter int NUM_CLASSES = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sba_cmd_t            cmd_i,
  output sba_sts_t            sts_o,
  input  logic [1:0]          in_req_type,
  input  logic [15:0]         in_request_bytes,
  input  logic [31:0]         in_free_address,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_user_address,
  output logic [CLS_W-1:0]    out_size_class
);

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  // Captured request.
  logic [1:0]        req_type_r;
  logic [15:0]       req_bytes_r;
  logic [31:0]       addr_r;

  // Carried between decode and the memory read.
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic              link_ok_r, link_ok_nxt;

  logic [LINK_W-1:0] heads_r   [NUM_CLASSES];
  logic [LINK_W-1:0] heads_nxt [NUM_CLASSES];
  logic [ADDR_W-1:0] cnext_r   [NUM_CLASSES];
  logic [ADDR_W-1:0] cnext_nxt [NUM_CLASSES];
  logic [LEFT_W-1:0] cleft_r   [NUM_CLASSES];
  logic [LEFT_W-1:0] cleft_nxt [NUM_CLASSES];
  logic [LINK_W-1:0] pool_top_r, pool_top_nxt;

  logic [LINK_W-1:0] mem [POOL_WORDS];
  logic [LINK_W-1:0] rd_data_r;
  logic [WORD_W-1:0] rd_addr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wa;
  logic [LINK_W-1:0] mem_wd;

  logic              res_valid;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [CLS_W-1:0]  res_cls;

  logic [16:0]       total;
  logic              found;
  logic [CLS_W-1:0]  ci;
  logic [CLS_W-1:0]  hidx;
  logic [LINK_W-1:0] head_rd;

  assign total = 17'(req_bytes_r) + 17'd4;

  // Smallest class that holds the request plus its header.
  always_comb begin
    found = 1'b0;
    ci    = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({5'd0, class_bytes(CLS_W'(i))} >= total) begin
        found = 1'b1;
        ci    = CLS_W'(i);
      end
    end
  end

  // One read port on the list heads: the chosen class in decode, the header class at the end.
  assign hidx    = cmd_i.fin ? rd_data_r[CLS_W-1:0] : ci;
  assign head_rd = heads_r[hidx[IDX_W-1:0]];

  always_comb begin
    logic [WORD_W:0]   link_word;
    logic [ADDR_W-1:0] cblk;
    logic              carve_ok;
    logic [ADDR_W-1:0] fblk;
    logic [LINK_W-1:0] link;
    logic              need_rd;

    heads_nxt    = heads_r;
    cnext_nxt    = cnext_r;
    cleft_nxt    = cleft_r;
    pool_top_nxt = pool_top_r;
    cls_nxt      = cls_r;
    blk_nxt      = blk_r;
    link_ok_nxt  = link_ok_r;
    rd_addr      = '0;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    res_valid    = 1'b0;
    res_status   = ST_OK;
    res_addr     = '0;
    res_cls      = '0;
    need_rd      = 1'b0;
    link_word    = '0;
    cblk         = '0;
    carve_ok     = 1'b0;
    fblk         = '0;
    link         = '0;

    if (cmd_i.dec) begin
      unique case (req_type_r)
        REQ_ALLOC: begin
          if (req_bytes_r == '0) begin
            res_valid  = 1'b1;
            res_status = ST_NULL;
          end else if (total > 17'(MAX_REQUEST_BYTES) || !found) begin
            res_valid  = 1'b1;
            res_status = ST_EXT;
          end else begin
            cls_nxt = ci;
            if (head_rd < LINK_W'(POOL_BYTES)) begin
              // Pop: the link sits in the word after the header.
              need_rd     = 1'b1;
              blk_nxt     = head_rd[ADDR_W-1:0];
              link_word   = (WORD_W+1)'(head_rd[ADDR_W-1:2]) + (WORD_W+1)'(1);
              link_ok_nxt = link_word < (WORD_W+1)'(POOL_WORDS);
              rd_addr     = link_word[WORD_W-1:0];
            end else if (cleft_r[ci[IDX_W-1:0]] != '0) begin
              cblk                       = cnext_r[ci[IDX_W-1:0]];
              cnext_nxt[ci[IDX_W-1:0]]   = cblk + ADDR_W'(class_bytes(ci));
              cleft_nxt[ci[IDX_W-1:0]]   = cleft_r[ci[IDX_W-1:0]] - LEFT_W'(1);
              carve_ok                   = 1'b1;
            end else if (chunk_bytes(ci) > LINK_W'(POOL_BYTES) - pool_top_r) begin
              res_valid  = 1'b1;
              res_status = ST_FULL;
              res_cls    = ci;
            end else begin
              cblk                     = pool_top_r[ADDR_W-1:0];
              cnext_nxt[ci[IDX_W-1:0]] = cblk + ADDR_W'(class_bytes(ci));
              cleft_nxt[ci[IDX_W-1:0]] = class_blocks(ci) - LEFT_W'(1);
              pool_top_nxt             = pool_top_r + chunk_bytes(ci);
              carve_ok                 = 1'b1;
            end
            if (carve_ok) begin
              mem_we     = 1'b1;
              mem_wa     = cblk[ADDR_W-1:2];
              mem_wd     = LINK_W'(ci);
              res_valid  = 1'b1;
              res_addr   = cblk + ADDR_W'(4);
              res_cls    = ci;
            end
          end
        end
        REQ_FREE: begin
          fblk = addr_r[ADDR_W-1:0] - ADDR_W'(4);
          if (addr_r < 32'd4 || addr_r[1:0] != 2'b00 || addr_r >= 32'(POOL_BYTES)) begin
            res_valid  = 1'b1;
            res_status = ST_EXT;
          end else if ({1'b0, fblk} >= pool_top_r) begin
            res_valid  = 1'b1;
            res_status = ST_EXT;
          end else begin
            need_rd = 1'b1;
            blk_nxt = fblk;
            rd_addr = fblk[ADDR_W-1:2];
          end
        end
        REQ_CLEAR: begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_nxt[i] = LINK_NULL;
            cnext_nxt[i] = '0;
            cleft_nxt[i] = '0;
          end
          pool_top_nxt = '0;
          res_valid    = 1'b1;
        end
        default: begin
          res_valid  = 1'b1;
          res_status = ST_EXT;
        end
      endcase
    end

    if (cmd_i.fin) begin
      if (req_type_r == REQ_ALLOC) begin
        link = link_ok_r ? rd_data_r : LINK_NULL;
        heads_nxt[cls_r[IDX_W-1:0]] = (link < LINK_W'(POOL_BYTES)) ? link : LINK_NULL;
        res_valid = 1'b1;
        res_addr  = blk_r + ADDR_W'(4);
        res_cls   = cls_r;
      end else if (rd_data_r >= LINK_W'(NUM_CLASSES)) begin
        res_valid  = 1'b1;
        res_status = ST_EXT;
      end else begin
        // Push: the old head goes into the link word, the block becomes the head.
        mem_we    = 1'b1;
        mem_wa    = addr_r[ADDR_W-1:2];
        mem_wd    = head_rd;
        heads_nxt[hidx[IDX_W-1:0]] = LINK_W'(blk_r);
        res_valid = 1'b1;
        res_addr  = addr_r[ADDR_W-1:0];
        res_cls   = rd_data_r[CLS_W-1:0];
      end
    end

    sts_o.need_rd = need_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      req_type_r  <= in_req_type;
      req_bytes_r <= in_request_bytes;
      addr_r      <= in_free_address;
    end
    cls_r     <= cls_nxt;
    blk_r     <= blk_nxt;
    link_ok_r <= link_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_r[i] <= LINK_NULL;
        cnext_r[i] <= '0;
        cleft_r[i] <= '0;
      end
      pool_top_r <= '0;
    end else begin
      heads_r    <= heads_nxt;
      cnext_r    <= cnext_nxt;
      cleft_r    <= cleft_nxt;
      pool_top_r <= pool_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= res_valid;
    end
    out_status       <= res_status;
    out_user_address <= res_addr;
    out_size_class   <= res_cls;
  end

endmodule

FILE: rtl/sba_checker.sv
// Port-level checks of the segregated block allocator and their bind.
module sba_checker import sba_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [1:0]        out_status,
  input logic [ADDR_W-1:0] out_user_address,
  input logic [CLS_W-1:0]  out_size_class
);

  // Two result strobes never come in a row, even for back-to-back requests.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result strobes in a row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a request in flight");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_user_address == '0))
    else $error("failed request returned an address");

  a_reject_cls_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_NULL || out_status == ST_EXT))
      |-> (out_size_class == '0))
    else $error("rejected request returned a class");

endmodule

bind segregated_block_allocator_top sba_checker u_sba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_user_address (out_user_address),
  .out_size_class   (out_size_class)
);

FILE: dv/segregated_block_allocator_top_test.sv
// Self-checking testbench for the segregated block allocator top level.
`timescale 1ns / 1ps

module segregated_block_allocator_top_test import sba_pkg::*;;

  localparam int unsigned NUM_CLS = 17;
  localparam int unsigned CLASS_BYTES [NUM_CLS] = '{
    12, 16, 28, 36, 60, 76, 88, 116, 148, 196, 260, 292, 436, 676, 868, 1068, 2076
  };
  localparam int unsigned CLASS_BLOCKS [NUM_CLS] = '{
    1024, 1024, 585, 455, 273, 215, 186, 141, 110, 83, 63, 56, 37, 24, 18, 15, 7
  };
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RETIRE_DEPTH = 64;
  localparam int unsigned TARGET_ITEMS = 950;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] user_address;
    logic [CLS_W-1:0]  size_class;
  } alloc_result_t;

  // Tracks the allocator state and the results still owed by the block.
  class block_alloc_tracker;
    bit [LINK_W-1:0] heads [NUM_CLS];
    bit [LINK_W-1:0] carve_next [NUM_CLS];
    bit [LEFT_W-1:0] carve_left [NUM_CLS];
    bit [LINK_W-1:0] pool_top;
    bit [LINK_W-1:0] words [int unsigned];
    alloc_result_t   pending_results [$];
    int unsigned     tally [4][4];
    int unsigned     failures;

    function new();
      empty_lists();
      failures = 0;
    endfunction

    function void empty_lists();
      foreach (heads[i]) begin
        heads[i] = LINK_NULL;
        carve_next[i] = '0;
        carve_left[i] = '0;
      end
      pool_top = '0;
    endfunction

    function bit [LINK_W-1:0] read_word(int unsigned idx);
      return words.exists(idx) ? words[idx] : '0;
    endfunction

    // A free inside the carved pool reads the header word; only words that
    // were written at some point may be read.
    function bit header_known(logic [31:0] addr);
      if (addr < 4 || addr[1:0] != 2'b00 || addr >= POOL_BYTES) return 1'b1;
      if (addr - 4 >= pool_top) return 1'b1;
      return words.exists((addr - 4) / 4) != 0;
    endfunction

    function alloc_result_t predict_alloc(logic [15:0] nbytes);
      alloc_result_t r;
      int unsigned total, blk, link, chunk, cls, i;
      bit found;
      r = '{ST_EXT, '0, '0};
      total = 32'(nbytes) + 4;
      found = 1'b0;
      cls = 0;
      if (nbytes == 0) begin
        r.status = ST_NULL;
        return r;
      end
      if (total > MAX_REQUEST_BYTES) return r;
      for (i = 0; i < NUM_CLS && !found; i++) begin
        if (CLASS_BYTES[i] >= total) begin
          cls = i;
          found = 1'b1;
        end
      end
      if (!found) return r;
      r.size_class = CLS_W'(cls);
      if (heads[cls] < POOL_BYTES) begin
        blk = 32'(heads[cls]);
        link = 32'(LINK_NULL);
        if (blk / 4 + 1 < POOL_WORDS) link = 32'(read_word(blk / 4 + 1));
        heads[cls] = (link < POOL_BYTES) ? LINK_W'(link) : LINK_NULL;
        r.status = ST_OK;
        r.user_address = ADDR_W'(blk + 4);
        return r;
      end
      if (carve_left[cls] != 0) begin
        blk = 32'(carve_next[cls]);
        carve_next[cls] = LINK_W'(blk + CLASS_BYTES[cls]);
        carve_left[cls] = carve_left[cls] - LEFT_W'(1);
      end else begin
        chunk = CLASS_BYTES[cls] * CLASS_BLOCKS[cls];
        if (pool_top > POOL_BYTES || chunk > POOL_BYTES - pool_top) begin
          r.status = ST_FULL;
          return r;
        end
        blk = 32'(pool_top);
        carve_next[cls] = LINK_W'(blk + CLASS_BYTES[cls]);
        carve_left[cls] = LEFT_W'(CLASS_BLOCKS[cls] - 1);
        pool_top = pool_top + LINK_W'(chunk);
      end
      if (blk / 4 < POOL_WORDS) words[blk / 4] = LINK_W'(cls);
      r.status = ST_OK;
      r.user_address = ADDR_W'(blk + 4);
      return r;
    endfunction

    function alloc_result_t predict_free(logic [31:0] addr);
      alloc_result_t r;
      int unsigned blk;
      bit [LINK_W-1:0] hdr;
      r = '{ST_EXT, '0, '0};
      if (addr < 4 || addr[1:0] != 2'b00 || addr >= POOL_BYTES) return r;
      blk = addr - 4;
      if (blk >= pool_top) return r;
      hdr = read_word(blk / 4);
      if (hdr >= NUM_CLS) return r;
      words[addr / 4] = heads[hdr];
      heads[hdr] = LINK_W'(blk);
      r.status = ST_OK;
      r.user_address = addr[ADDR_W-1:0];
      r.size_class = hdr[CLS_W-1:0];
      return r;
    endfunction

    function alloc_result_t record_request(logic [1:0] kind, logic [15:0] nbytes,
                                           logic [31:0] addr);
      alloc_result_t r;
      case (kind)
        REQ_ALLOC: r = predict_alloc(nbytes);
        REQ_FREE:  r = predict_free(addr);
        REQ_CLEAR: begin
          empty_lists();
          r = '{ST_OK, '0, '0};
        end
        default:   r = '{ST_EXT, '0, '0};
      endcase
      tally[kind][r.status]++;
      pending_results.push_back(r);
      return r;
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void compare_result(logic [1:0] st, logic [ADDR_W-1:0] ua, logic [CLS_W-1:0] sc);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d address 0x%05h class %0d",
                              st, ua, sc));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status || ua !== want.user_address || sc !== want.size_class)
        log_failure($sformatf({"expected status %0d address 0x%05h class %0d, ",
                               "got status %0d address 0x%05h class %0d"},
                              want.status, want.user_address, want.size_class, st, ua, sc));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_req_type = REQ_ALLOC;
  logic [15:0]       in_request_bytes = '0;
  logic [31:0]       in_free_address = '0;
  logic              out_strobe;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_user_address;
  logic [CLS_W-1:0]  out_size_class;

  block_alloc_tracker tracker;
  alloc_result_t      last_result;
  int unsigned        live_addrs [$];
  int unsigned        retired [$];
  int unsigned        items_sent = 0;
  int unsigned        quiet_cycles = 0;
  bit                 no_gaps = 1'b0;

  segregated_block_allocator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_request_bytes (in_request_bytes),
    .in_free_address  (in_free_address),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_size_class   (out_size_class)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0)
      tracker.compare_result(out_status, out_user_address, out_size_class);
    if ((start && !busy) || out_strobe === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("segregated_block_allocator_top: mismatch");
    $finish;
  end

  function automatic void retire(int unsigned addr);
    retired.push_back(addr);
    if (retired.size() > RETIRE_DEPTH) void'(retired.pop_front());
  endfunction

  // Holds the request until the transfer completes, then predicts its result.
  task automatic send_req(input logic [1:0] kind, input logic [15:0] nbytes,
                          input logic [31:0] addr);
    while (!no_gaps && $urandom_range(99) < 34) begin
      start <= 1'b0;
      in_req_type <= 2'($urandom);
      in_request_bytes <= 16'($urandom);
      in_free_address <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_request_bytes <= nbytes;
    in_free_address <= addr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    last_result = tracker.record_request(kind, nbytes, addr);
    items_sent++;
    if (kind == REQ_ALLOC && last_result.status == ST_OK)
      live_addrs.push_back(32'(last_result.user_address));
    if (kind == REQ_CLEAR) begin
      while (live_addrs.size() != 0) retire(live_addrs.pop_back());
    end
  endtask

  // Mostly balanced allocate/free traffic with some malformed requests mixed in.
  task automatic churn_phase(input int unsigned count);
    logic [1:0]  kind;
    logic [15:0] nbytes;
    logic [31:0] addr;
    int unsigned roll, idx, base;
    repeat (count) begin
      roll = $urandom_range(99);
      kind = REQ_ALLOC;
      nbytes = 16'($urandom);
      addr = $urandom;
      if (roll < 48 || (roll < 84 && live_addrs.size() == 0)) begin
        nbytes = ($urandom_range(3) != 0) ? 16'($urandom_range(1, 120))
                                          : 16'($urandom_range(121, 2072));
      end else if (roll < 84) begin
        idx = $urandom_range(live_addrs.size() - 1);
        kind = REQ_FREE;
        addr = live_addrs[idx];
        live_addrs.delete(idx);
        retire(addr);
      end else if (roll == 84) begin
        kind = REQ_CLEAR;
      end else begin
        if (live_addrs.size() != 0 && $urandom_range(1) == 0)
          base = live_addrs[$urandom_range(live_addrs.size() - 1)];
        else if (retired.size() != 0)
          base = retired[$urandom_range(retired.size() - 1)];
        else
          base = $urandom_range(4, 4096);
        case ($urandom_range(7))
          0: nbytes = '0;
          1: nbytes = 16'($urandom_range(2073, 65535));
          2: kind = REQ_NONE;
          3: kind = REQ_FREE;
          4: begin
            kind = REQ_FREE;
            addr = base;
          end
          5: begin
            kind = REQ_FREE;
            addr = base + $urandom_range(1, 3);
          end
          6: begin
            kind = REQ_FREE;
            addr = base + 4 * $urandom_range(1, 3);
          end
          default: begin
            kind = REQ_FREE;
            addr = $urandom_range(1, POOL_WORDS - 1) * 4;
          end
        endcase
        // Steer frees that would read a never-written word outside the pool.
        if (kind == REQ_FREE && !tracker.header_known(addr)) addr = $urandom | POOL_BYTES;
      end
      send_req(kind, nbytes, addr);
    end
  endtask

  initial begin : stimulus
    int unsigned first_addr, mid_addr, fill_items, idx;
    logic [15:0] nbytes;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size boundaries, rejects, double free, bad header, stale header.
    send_req(REQ_ALLOC, 16'd1, '0);
    first_addr = 32'(last_result.user_address);
    send_req(REQ_ALLOC, 16'd8, '0);
    send_req(REQ_ALLOC, 16'd9, '0);
    mid_addr = 32'(last_result.user_address);
    send_req(REQ_ALLOC, 16'd2072, '0);
    send_req(REQ_ALLOC, 16'd2073, '0);
    send_req(REQ_ALLOC, 16'd0, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(REQ_FREE, 16'hFFFF, first_addr);
    send_req(REQ_FREE, '0, first_addr);
    send_req(REQ_ALLOC, 16'd4, '0);
    send_req(REQ_FREE, '0, 32'd0);
    send_req(REQ_FREE, '0, mid_addr + 2);
    send_req(REQ_FREE, '0, 32'hFFFF_FFFF);
    send_req(REQ_FREE, '0, POOL_BYTES - 4);
    send_req(REQ_FREE, '0, mid_addr);
    // The header slot of this address now holds a free-list link.
    send_req(REQ_FREE, '0, mid_addr + 4);
    send_req(REQ_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_FREE, '0, mid_addr);
    send_req(REQ_ALLOC, 16'd2072, '0);
    send_req(REQ_ALLOC, 16'd1, '0);
    // The old header below the new pool top is still in memory.
    send_req(REQ_FREE, '0, mid_addr);
    send_req(REQ_ALLOC, 16'd9, '0);

    churn_phase(200);
    send_req(REQ_CLEAR, 16'($urandom), $urandom);

    // Fill the pool with large blocks until allocations run out of chunks.
    fill_items = 0;
    while (tracker.tally[REQ_ALLOC][ST_FULL] < 12 && fill_items < 600) begin
      no_gaps = (fill_items >= 100 && fill_items < 300);
      if (live_addrs.size() != 0 && $urandom_range(9) == 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        send_req(REQ_FREE, 16'($urandom), live_addrs[idx]);
        live_addrs.delete(idx);
      end else begin
        nbytes = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 1064))
                                          : 16'($urandom_range(1065, 2072));
        send_req(REQ_ALLOC, nbytes, $urandom);
      end
      fill_items++;
    end
    no_gaps = 1'b0;
    send_req(REQ_CLEAR, 16'($urandom), $urandom);

    churn_phase((items_sent + 150 < TARGET_ITEMS) ? TARGET_ITEMS - items_sent : 150);

    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests: %0d allocations granted, %0d pool exhausted,",
             items_sent, tracker.tally[REQ_ALLOC][ST_OK], tracker.tally[REQ_ALLOC][ST_FULL]);
    $display("%0d zero-size, %0d oversized, %0d frees taken, %0d refused, %0d clears.",
             tracker.tally[REQ_ALLOC][ST_NULL], tracker.tally[REQ_ALLOC][ST_EXT],
             tracker.tally[REQ_FREE][ST_OK], tracker.tally[REQ_FREE][ST_EXT],
             tracker.tally[REQ_CLEAR][ST_OK]);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0)
      $display("segregated_block_allocator_top: match");
    else
      $display("segregated_block_allocator_top: mismatch");
    $finish;
  end

endmodule

FILE: segregated_block_allocator_top.f
rtl/sba_pkg.sv
rtl/sba_ctrl.sv
rtl/sba_datapath.sv
rtl/segregated_block_allocator_top.sv
rtl/sba_checker.sv
dv/segregated_block_allocator_top_test.sv
